// ----- rtl/core/keyed_min_max_sum_aggregator_assert.svh -----
// ----------------------------------------------------------------------------
// keyed min/max/sum aggregator assertion macros
// shorthand for the clocked assertions used by the port checker
// ----------------------------------------------------------------------------
`ifndef KEYED_MIN_MAX_SUM_AGGREGATOR_ASSERT_SVH
`define KEYED_MIN_MAX_SUM_AGGREGATOR_ASSERT_SVH

// condition holds at every edge out of reset
`define KMMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmms assertion failed");

// condition in the cycle after the trigger
`define KMMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmms assertion failed");

`endif

// ----- rtl/core/kmms_pkg.sv -----
// ----------------------------------------------------------------------------
// kmms_pkg
// shared types, codes and defaults of the keyed min/max/sum aggregator
// ----------------------------------------------------------------------------
package kmms_pkg;

    localparam int TABLE_SLOTS_DEF    = 16384;
    localparam int MAX_ENTRIES_DEF    = 8192;
    localparam int KEY_BYTES_DEF      = 128;
    localparam int MAX_LINE_BYTES_DEF = 256;
    localparam int QUEUE_DEPTH_DEF    = 2;

    localparam int KLEN_W    = 9;
    localparam int VAL_W     = 11;
    localparam int SUM_W     = 48;
    localparam int CNT_W     = 32;
    localparam int IDX_W     = 13;
    localparam int WSEL_W    = 4;
    localparam int KWORD_W   = 64;
    localparam int TOTAL_W   = 14;
    localparam int HASH_W    = 32;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [HASH_W-1:0] HASH_MULT = 32'd31;

    localparam logic CMD_STREAM = 1'b0;
    localparam logic CMD_READ   = 1'b1;
    localparam logic KIND_LINE  = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK,
        ST_FULL,
        ST_LONG,
        ST_BADNUM,
        ST_UNUSED
    } status_t;

    typedef enum logic [2:0] {
        PH_NAME,
        PH_SIGN,
        PH_NEG,
        PH_INT,
        PH_DOT,
        PH_FRAC
    } phase_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_RD_WAIT,
        B_MOD,
        B_SLOT_RD,
        B_SLOT_CHK,
        B_LEN_CHK,
        B_KEY_CHK,
        B_STAT,
        B_COPY,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic                    is_read;
        status_t                 status;
        logic [HASH_W-1:0]       hash;
        logic signed [VAL_W-1:0] value;
        logic [KLEN_W-1:0]       klen;
        logic [KWORD_W-1:0]      word0;
        logic [IDX_W-1:0]        read_index;
        logic [WSEL_W-1:0]       read_word;
    } job_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] mn;
        logic signed [VAL_W-1:0] mx;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        cnt;
    } stat_t;

    typedef struct packed {
        logic               kind;
        logic [IDX_W-1:0]   entry_index;
        logic               is_new;
        status_t            status;
        logic [KWORD_W-1:0] key_word;
        logic [7:0]         key_length;
        stat_t              stat;
        logic [TOTAL_W-1:0] total;
    } result_t;

    typedef struct packed {
        logic clearing;
        logic release_key;
    } back_status_t;

endpackage

// ----- rtl/core/kmms_queue.sv -----
// ----------------------------------------------------------------------------
// kmms_queue
// short job queue between the parser and the table engine
// ----------------------------------------------------------------------------
module kmms_queue #(
    parameter int DEPTH = kmms_pkg::QUEUE_DEPTH_DEF,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  kmms_pkg::job_t push_job,
    input  logic           pop,
    output kmms_pkg::job_t head,
    output logic           full,
    output logic           empty
);
    import kmms_pkg::*;

    job_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/core/kmms_front.sv -----
// ----------------------------------------------------------------------------
// kmms_front
// line parser: key buffer, running hash, value parse, job dispatch
// ----------------------------------------------------------------------------
module kmms_front #(
    parameter int KEY_BYTES      = kmms_pkg::KEY_BYTES_DEF,
    parameter int MAX_LINE_BYTES = kmms_pkg::MAX_LINE_BYTES_DEF,
    localparam int KEY_WORDS = (KEY_BYTES + 7) / 8,
    localparam int WW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_cmd,
    input  logic [7:0]                     in_byte,
    input  logic [kmms_pkg::IDX_W-1:0]     in_read_index,
    input  logic [kmms_pkg::WSEL_W-1:0]    in_read_word,
    output logic                           push,
    output kmms_pkg::job_t                 job,
    input  logic                           q_full,
    input  kmms_pkg::back_status_t         bst,
    input  logic [WW-1:0]                  kbuf_index,
    output logic [kmms_pkg::KWORD_W-1:0]   kbuf_word
);
    import kmms_pkg::*;

    localparam int LW = $clog2(MAX_LINE_BYTES + 1);

    logic [KWORD_W-1:0] kbuf_reg [KEY_WORDS];
    logic [KWORD_W-1:0] kbuf_next [KEY_WORDS];
    logic [KLEN_W-1:0]  fill_reg, fill_next;
    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic [9:0]         accum_reg, accum_next;
    phase_t             phase_reg, phase_next;
    logic [1:0]         digits_reg, digits_next;
    logic               neg_reg, neg_next;
    logic               bad_reg, bad_next;
    logic               long_reg, long_next;
    logic [LW-1:0]      len_reg, len_next;
    logic               lock_reg, lock_next;

    logic               accept;
    logic [LW-1:0]      len_inc;
    logic               is_digit;
    logic [9:0]         accum_mac;
    logic [VAL_W-1:0]   vmag;
    logic [WW-1:0]      widx;

    assign in_ready  = !bst.clearing && !q_full && ((in_cmd == CMD_READ) || !lock_reg);
    assign accept    = in_valid && in_ready;
    assign push      = accept && ((in_cmd == CMD_READ) || (in_byte == CHAR_NL));
    assign len_inc   = len_reg + LW'(1);
    assign is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
    assign accum_mac = 10'(accum_reg * 10'd10 + {6'b0, in_byte[3:0]});
    assign vmag      = (phase_reg == PH_INT) ? VAL_W'({1'b0, accum_reg} * 11'd10)
                                             : VAL_W'({1'b0, accum_reg});
    assign widx      = fill_reg[WW+2:3];
    assign kbuf_word = kbuf_reg[kbuf_index];

    always_comb
    begin
        job.is_read    = in_cmd;
        job.status     = long_reg ? ST_LONG
                       : (bad_reg || !((phase_reg == PH_INT) || (phase_reg == PH_FRAC)))
                       ? ST_BADNUM : ST_OK;
        job.hash       = hash_reg;
        job.value      = neg_reg ? -vmag : vmag;
        job.klen       = fill_reg;
        job.word0      = kbuf_reg[0];
        job.read_index = in_read_index;
        job.read_word  = in_read_word;
    end

    always_comb
    begin
        kbuf_next   = kbuf_reg;
        fill_next   = fill_reg;
        hash_next   = hash_reg;
        accum_next  = accum_reg;
        phase_next  = phase_reg;
        digits_next = digits_reg;
        neg_next    = neg_reg;
        bad_next    = bad_reg;
        long_next   = long_reg;
        len_next    = len_reg;
        lock_next   = lock_reg;
        if (bst.release_key)
        begin
            for (int w = 0; w < KEY_WORDS; w++)
            begin
                kbuf_next[w] = '0;
            end
            lock_next = 1'b0;
        end
        if (accept && (in_cmd == CMD_STREAM))
        begin
            if (in_byte == CHAR_NL)
            begin
                fill_next   = '0;
                hash_next   = '0;
                accum_next  = '0;
                phase_next  = PH_NAME;
                digits_next = '0;
                neg_next    = 1'b0;
                bad_next    = 1'b0;
                long_next   = 1'b0;
                len_next    = '0;
                lock_next   = 1'b1;
            end
            else if (!long_reg)
            begin
                len_next = len_inc;
                if (len_inc > LW'(MAX_LINE_BYTES - 1))
                begin
                    long_next = 1'b1;
                end
                else if (phase_reg == PH_NAME)
                begin
                    if (in_byte == CHAR_SEMI)
                    begin
                        phase_next = PH_SIGN;
                    end
                    else if (fill_reg >= KLEN_W'(KEY_BYTES))
                    begin
                        long_next = 1'b1;
                    end
                    else
                    begin
                        kbuf_next[widx][{fill_reg[2:0], 3'b000} +: 8] = in_byte;
                        fill_next = fill_reg + KLEN_W'(1);
                        hash_next = HASH_W'(hash_reg * HASH_MULT + {24'b0, in_byte});
                    end
                end
                else if ((phase_reg == PH_SIGN) && (in_byte == CHAR_MINUS))
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_NEG;
                end
                else if ((phase_reg == PH_SIGN) || (phase_reg == PH_NEG)
                         || (phase_reg == PH_INT))
                begin
                    if (is_digit && (digits_reg < 2'd2))
                    begin
                        accum_next  = accum_mac;
                        digits_next = digits_reg + 2'd1;
                        phase_next  = PH_INT;
                    end
                    else if ((in_byte == CHAR_DOT) && (phase_reg == PH_INT))
                    begin
                        phase_next = PH_DOT;
                    end
                    else
                    begin
                        bad_next = 1'b1;
                    end
                end
                else if ((phase_reg == PH_DOT) && is_digit)
                begin
                    accum_next = accum_mac;
                    phase_next = PH_FRAC;
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < KEY_WORDS; w++)
            begin
                kbuf_reg[w] <= '0;
            end
            fill_reg   <= '0;
            hash_reg   <= '0;
            accum_reg  <= '0;
            phase_reg  <= PH_NAME;
            digits_reg <= '0;
            neg_reg    <= 1'b0;
            bad_reg    <= 1'b0;
            long_reg   <= 1'b0;
            len_reg    <= '0;
            lock_reg   <= 1'b0;
        end
        else
        begin
            kbuf_reg   <= kbuf_next;
            fill_reg   <= fill_next;
            hash_reg   <= hash_next;
            accum_reg  <= accum_next;
            phase_reg  <= phase_next;
            digits_reg <= digits_next;
            neg_reg    <= neg_next;
            bad_reg    <= bad_next;
            long_reg   <= long_next;
            len_reg    <= len_next;
            lock_reg   <= lock_next;
        end
    end

endmodule

// ----- rtl/core/kmms_back.sv -----
// ----------------------------------------------------------------------------
// kmms_back
// table engine: slot probing, key compare, entry insert/update, read-back
// ----------------------------------------------------------------------------
module kmms_back #(
    parameter int TABLE_SLOTS = kmms_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_ENTRIES = kmms_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BYTES   = kmms_pkg::KEY_BYTES_DEF,
    localparam int KEY_WORDS = (KEY_BYTES + 7) / 8,
    localparam int WW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  kmms_pkg::job_t               head,
    output logic                         pop,
    output logic [WW-1:0]                kbuf_index,
    input  logic [kmms_pkg::KWORD_W-1:0] kbuf_word,
    output kmms_pkg::back_status_t       bst,
    output logic                         out_valid,
    input  logic                         out_ready,
    output kmms_pkg::result_t            out_res
);
    import kmms_pkg::*;

    localparam int SW  = $clog2(TABLE_SLOTS);
    localparam int PW  = $clog2(TABLE_SLOTS + 1);
    localparam int RW  = SW + 1;
    localparam int EW  = $clog2(MAX_ENTRIES);
    localparam int UW  = $clog2(MAX_ENTRIES + 1);
    localparam int KAW = EW + WW;
    localparam logic [RW-1:0] T_R = RW'(TABLE_SLOTS);

    // storage
    logic [EW:0]         slot_mem [TABLE_SLOTS];
    logic [KWORD_W-1:0]  key_mem  [MAX_ENTRIES * (2 ** WW)];
    logic [KLEN_W-1:0]   len_mem  [MAX_ENTRIES];
    stat_t               stat_mem [MAX_ENTRIES];

    logic                slot_we;
    logic [SW-1:0]       slot_wa, slot_ra;
    logic [EW:0]         slot_wd, slot_rd_reg;
    logic                key_we;
    logic [KAW-1:0]      key_wa, key_ra;
    logic [KWORD_W-1:0]  key_wd, key_rd_reg;
    logic                len_we;
    logic [EW-1:0]       len_wa, len_ra;
    logic [KLEN_W-1:0]   len_wd, len_rd_reg;
    logic                stat_we;
    logic [EW-1:0]       stat_wa, stat_ra;
    stat_t               stat_wd, stat_rd_reg;

    back_state_t         state_reg, state_next;
    job_t                job_reg, job_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic [PW-1:0]       probe_reg, probe_next;
    logic [EW-1:0]       entry_reg, entry_next;
    logic [WW-1:0]       word_reg, word_next;
    logic [UW-1:0]       used_reg, used_next;
    logic [RW-1:0]       rem_reg, rem_next;
    logic [HASH_W-1:0]   hsh_reg, hsh_next;
    logic [2:0]          step_reg, step_next;
    logic [SW-1:0]       clr_reg, clr_next;
    result_t             res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_res_reg, out_res_next;

    logic                miss;
    logic                emit;
    logic [RW-1:0]       rem_step;
    logic [KLEN_W-1:0]   nwords;
    stat_t               upd;
    stat_t               init;

    assign out_valid       = out_valid_reg;
    assign out_res         = out_res_reg;
    assign bst.clearing    = (state_reg == B_CLEAR);
    assign emit            = (state_reg == B_EMIT) && (!out_valid_reg || out_ready);
    assign bst.release_key = emit && !job_reg.is_read;
    assign nwords          = (job_reg.klen + KLEN_W'(7)) >> 3;

    function automatic result_t line_fail(job_t j, status_t st, logic [UW-1:0] used);
        result_t r;
        r             = '0;
        r.kind        = KIND_LINE;
        r.status      = st;
        r.key_word    = j.word0;
        r.key_length  = 8'(j.klen);
        r.total       = TOTAL_W'(used);
        return r;
    endfunction

    always_comb
    begin
        logic [RW-1:0] r;
        r = rem_reg;
        for (int k = 0; k < 4; k++)
        begin
            r = {r[RW-2:0], hsh_reg[HASH_W-1-k]};
            if (r >= T_R)
            begin
                r = r - T_R;
            end
        end
        rem_step = r;
    end

    always_comb
    begin
        upd.mn  = (job_reg.value < stat_rd_reg.mn) ? job_reg.value : stat_rd_reg.mn;
        upd.mx  = (job_reg.value > stat_rd_reg.mx) ? job_reg.value : stat_rd_reg.mx;
        upd.sum = stat_rd_reg.sum + SUM_W'(job_reg.value);
        upd.cnt = (stat_rd_reg.cnt == '1) ? stat_rd_reg.cnt : stat_rd_reg.cnt + CNT_W'(1);
        init.mn  = job_reg.value;
        init.mx  = job_reg.value;
        init.sum = SUM_W'(job_reg.value);
        init.cnt = CNT_W'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        slot_next  = slot_reg;
        probe_next = probe_reg;
        entry_next = entry_reg;
        word_next  = word_reg;
        used_next  = used_reg;
        rem_next   = rem_reg;
        hsh_next   = hsh_reg;
        step_next  = step_reg;
        clr_next   = clr_reg;
        res_next   = res_reg;
        pop        = 1'b0;
        miss       = 1'b0;
        kbuf_index = word_reg;
        slot_we    = 1'b0;
        slot_wa    = slot_reg;
        slot_wd    = '0;
        slot_ra    = slot_reg;
        key_we     = 1'b0;
        key_wa     = {entry_reg, word_reg};
        key_wd     = kbuf_word;
        key_ra     = {entry_reg, word_reg};
        len_we     = 1'b0;
        len_wa     = entry_reg;
        len_wd     = job_reg.klen;
        len_ra     = entry_reg;
        stat_we    = 1'b0;
        stat_wa    = entry_reg;
        stat_wd    = upd;
        stat_ra    = entry_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                slot_we  = 1'b1;
                slot_wa  = clr_reg;
                clr_next = clr_reg + SW'(1);
                if (clr_reg == SW'(TABLE_SLOTS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    job_next = head;
                    if (head.is_read)
                    begin
                        if (16'(head.read_index) >= 16'(used_reg))
                        begin
                            res_next             = '0;
                            res_next.kind        = KIND_READ;
                            res_next.entry_index = head.read_index;
                            res_next.status      = ST_UNUSED;
                            res_next.total       = TOTAL_W'(used_reg);
                            state_next           = B_EMIT;
                        end
                        else
                        begin
                            key_ra     = {EW'(head.read_index), WW'(head.read_word)};
                            len_ra     = EW'(head.read_index);
                            stat_ra    = EW'(head.read_index);
                            state_next = B_RD_WAIT;
                        end
                    end
                    else if (head.status != ST_OK)
                    begin
                        res_next   = line_fail(head, head.status, used_reg);
                        state_next = B_EMIT;
                    end
                    else
                    begin
                        hsh_next   = head.hash;
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = B_MOD;
                    end
                end
            end
            B_RD_WAIT:
            begin
                res_next             = '0;
                res_next.kind        = KIND_READ;
                res_next.entry_index = job_reg.read_index;
                res_next.status      = ST_OK;
                res_next.key_word    = (16'(job_reg.read_word) < 16'(KEY_WORDS))
                                     ? key_rd_reg : '0;
                res_next.key_length  = 8'(len_rd_reg);
                res_next.stat        = stat_rd_reg;
                res_next.total       = TOTAL_W'(used_reg);
                state_next           = B_EMIT;
            end
            B_MOD:
            begin
                rem_next  = rem_step;
                hsh_next  = {hsh_reg[HASH_W-5:0], 4'b0000};
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    slot_next  = rem_step[SW-1:0];
                    probe_next = '0;
                    state_next = B_SLOT_RD;
                end
            end
            B_SLOT_RD:
            begin
                state_next = B_SLOT_CHK;
            end
            B_SLOT_CHK:
            begin
                if (!slot_rd_reg[EW])
                begin
                    if (used_reg >= UW'(MAX_ENTRIES))
                    begin
                        res_next   = line_fail(job_reg, ST_FULL, used_reg);
                        state_next = B_EMIT;
                    end
                    else
                    begin
                        entry_next = EW'(used_reg);
                        slot_we    = 1'b1;
                        slot_wd    = {1'b1, EW'(used_reg)};
                        word_next  = '0;
                        state_next = B_COPY;
                    end
                end
                else
                begin
                    entry_next = slot_rd_reg[EW-1:0];
                    len_ra     = slot_rd_reg[EW-1:0];
                    state_next = B_LEN_CHK;
                end
            end
            B_LEN_CHK:
            begin
                if (len_rd_reg != job_reg.klen)
                begin
                    miss = 1'b1;
                end
                else if (nwords == '0)
                begin
                    state_next = B_STAT;
                end
                else
                begin
                    key_ra     = {entry_reg, WW'(0)};
                    word_next  = '0;
                    state_next = B_KEY_CHK;
                end
            end
            B_KEY_CHK:
            begin
                if (key_rd_reg != kbuf_word)
                begin
                    miss = 1'b1;
                end
                else if (KLEN_W'(word_reg) + KLEN_W'(1) == nwords)
                begin
                    state_next = B_STAT;
                end
                else
                begin
                    word_next = word_reg + WW'(1);
                    key_ra    = {entry_reg, word_reg + WW'(1)};
                end
            end
            B_STAT:
            begin
                stat_we              = 1'b1;
                stat_wd              = upd;
                res_next             = line_fail(job_reg, ST_OK, used_reg);
                res_next.entry_index = IDX_W'(entry_reg);
                res_next.stat        = upd;
                state_next           = B_EMIT;
            end
            B_COPY:
            begin
                key_we = 1'b1;
                if (word_reg == WW'(KEY_WORDS - 1))
                begin
                    len_we               = 1'b1;
                    stat_we              = 1'b1;
                    stat_wd              = init;
                    used_next            = used_reg + UW'(1);
                    res_next             = line_fail(job_reg, ST_OK, used_reg + UW'(1));
                    res_next.entry_index = IDX_W'(entry_reg);
                    res_next.is_new      = 1'b1;
                    res_next.stat        = init;
                    state_next           = B_EMIT;
                end
                else
                begin
                    word_next = word_reg + WW'(1);
                end
            end
            B_EMIT:
            begin
                if (emit)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        if (miss)
        begin
            if (probe_reg == PW'(TABLE_SLOTS - 1))
            begin
                res_next   = line_fail(job_reg, ST_FULL, used_reg);
                state_next = B_EMIT;
            end
            else
            begin
                probe_next = probe_reg + PW'(1);
                slot_next  = (slot_reg == SW'(TABLE_SLOTS - 1)) ? '0 : slot_reg + SW'(1);
                state_next = B_SLOT_RD;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        slot_reg    <= slot_next;
        probe_reg   <= probe_next;
        entry_reg   <= entry_next;
        word_reg    <= word_next;
        rem_reg     <= rem_next;
        hsh_reg     <= hsh_next;
        step_reg    <= step_next;
        res_reg     <= res_next;
        out_res_reg <= out_res_next;
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rd_reg <= slot_mem[slot_ra];
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        key_rd_reg <= key_mem[key_ra];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_wa] <= len_wd;
        end
        len_rd_reg <= len_mem[len_ra];
    end

    always_ff @(posedge clk)
    begin
        if (stat_we)
        begin
            stat_mem[stat_wa] <= stat_wd;
        end
        stat_rd_reg <= stat_mem[stat_ra];
    end

endmodule

// ----- rtl/core/keyed_min_max_sum_aggregator.sv -----
// ----------------------------------------------------------------------------
// keyed_min_max_sum_aggregator
// per-key min, max, sum and count over a "name;value" text stream
// ----------------------------------------------------------------------------
// input channel s_axis: tuser 0 carries a text byte, tuser 1 a read request.
// output channel m_axis: one item per newline (tuser 0) and per read (tuser 1).
// text bytes other than newline give no output item.
// a newline is handed to the table engine through a two-deep job queue; the
// parser then holds further text bytes until the engine has used the key.
// line steps: dispatch, hash remainder mod TABLE_SLOTS (4 bits per cycle), then
// per occupied slot a slot read, slot check, length check and, when the length
// matches, a key compare 8 bytes at a time; for an empty slot a slot read and
// check; then the update or a new key copy 8 bytes at a time; output register.
// a read of a used entry waits for a memory read before the output register.
// after reset the slot store is swept, one slot per cycle;
// s_axis_tready stays low until the sweep is done.
// a stalled output holds its item; requests queue behind it while the queue
// has room, and after a newline the parser waits until that line's item has
// reached the output register.
// ----------------------------------------------------------------------------
module keyed_min_max_sum_aggregator #(
    parameter int TABLE_SLOTS    = kmms_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_ENTRIES    = kmms_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BYTES      = kmms_pkg::KEY_BYTES_DEF,
    parameter int MAX_LINE_BYTES = kmms_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // data_byte, read_index, read_word
    input  logic         s_axis_tuser,  // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [207:0] m_axis_tdata,  // entry_index, is_new, status, key_word,
                                        // key_length, min_tenths, max_tenths,
                                        // sum_tenths, sample_count, entry_total
    output logic         m_axis_tuser   // kind
);
    import kmms_pkg::*;

    localparam int KEY_WORDS = (KEY_BYTES + 7) / 8;
    localparam int WW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

    logic               push, pop, q_full, q_empty;
    job_t               push_job, head;
    back_status_t       bst;
    logic [WW-1:0]      kbuf_index;
    logic [KWORD_W-1:0] kbuf_word;
    result_t            res;

    kmms_front #(
        .KEY_BYTES      (KEY_BYTES),
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_cmd        (s_axis_tuser),
        .in_byte       (s_axis_tdata[7:0]),
        .in_read_index (s_axis_tdata[20:8]),
        .in_read_word  (s_axis_tdata[24:21]),
        .push          (push),
        .job           (push_job),
        .q_full        (q_full),
        .bst           (bst),
        .kbuf_index    (kbuf_index),
        .kbuf_word     (kbuf_word)
    );

    kmms_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    kmms_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BYTES   (KEY_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head       (head),
        .pop        (pop),
        .kbuf_index (kbuf_index),
        .kbuf_word  (kbuf_word),
        .bst        (bst),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (res)
    );

    assign m_axis_tuser = res.kind;
    assign m_axis_tdata = {3'b000, res.total, res.stat.cnt, res.stat.sum, res.stat.mx,
                           res.stat.mn, res.key_length, res.key_word, res.status,
                           res.is_new, res.entry_index};

endmodule

// ----- rtl/core/kmms_checker.sv -----
// ----------------------------------------------------------------------------
// kmms_checker
// port-level checks on the aggregator result stream
// ----------------------------------------------------------------------------
`include "keyed_min_max_sum_aggregator_assert.svh"

module kmms_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [207:0] m_axis_tdata,
    input logic         m_axis_tuser
);
    import kmms_pkg::*;

    logic [2:0]  st;
    logic [31:0] cnt;
    logic        ok;

    assign st  = m_axis_tdata[16:14];
    assign cnt = m_axis_tdata[190:159];
    assign ok  = (st == ST_OK);

    // stalled result item holds
    `KMMS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    // any failure carries no statistics and no new entry
    `KMMS_ASSERT_IMPLY(a_fail_empty, clk, rst_n, m_axis_tvalid && !ok, (cnt == '0) && !m_axis_tdata[13] && (m_axis_tdata[158:89] == '0))
    // a fresh entry has been seen exactly once
    `KMMS_ASSERT_IMPLY(a_new_once, clk, rst_n, m_axis_tvalid && m_axis_tdata[13], ok && (m_axis_tuser == KIND_LINE) && (cnt == 32'd1))
    // a good result always has at least one sample
    `KMMS_ASSERT_IMPLY(a_ok_count, clk, rst_n, m_axis_tvalid && ok, cnt != '0)

endmodule

bind keyed_min_max_sum_aggregator kmms_checker u_kmms_checker (.*);

// ----- tb/tb_keyed_min_max_sum_aggregator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_min_max_sum_aggregator
// drives text lines and read requests into the aggregator, predicts each line
// and read result with an in-bench hash table and checks every output item
// ----------------------------------------------------------------------------
module tb_keyed_min_max_sum_aggregator;
    import kmms_pkg::*;

    localparam int SLOTS    = 16384;
    localparam int ENTRIES  = 8192;
    localparam int KBYTES   = 128;
    localparam int KWORDS   = KBYTES / 8;
    localparam int LINE_MAX = 256;

    typedef struct {
        logic        cmd;
        logic [7:0]  data_byte;
        logic [12:0] read_index;
        logic [3:0]  read_word;
        bit          hold;
    } in_item_t;

    typedef struct {
        logic               kind;
        logic [12:0]        entry_index;
        logic               is_new;
        logic [2:0]         status;
        logic [63:0]        key_word;
        logic [7:0]         key_length;
        logic signed [10:0] mn;
        logic signed [10:0] mx;
        logic [47:0]        sum;
        logic [31:0]        cnt;
        logic [13:0]        total;
    } agg_result_t;

    typedef byte unsigned bytes_t[$];

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [207:0] m_axis_tdata;
    logic         m_axis_tuser;

    keyed_min_max_sum_aggregator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    in_item_t    pending_items[$];
    agg_result_t expected_results[$];
    in_item_t    cur_item;
    int          items_sent;
    int          items_total;
    bit          stimulus_ready;
    int          mismatches;

    // table model
    bit          slot_used[SLOTS];
    int          slot_entry[SLOTS];
    logic [63:0] stored_key[ENTRIES][KWORDS];
    int          stored_len[ENTRIES];
    int          st_min[ENTRIES];
    int          st_max[ENTRIES];
    longint      st_sum[ENTRIES];
    logic [31:0] st_cnt[ENTRIES];
    int          keys_stored;

    // line parser model
    logic [63:0] line_key[KWORDS];
    int          key_fill;
    logic [31:0] line_hash;
    int          value_acc;
    phase_t      phase;
    int          int_digits;
    bit          neg_value;
    bit          bad_number;
    bit          too_long;
    int          line_len;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic clear_line();
        for (int w = 0; w < KWORDS; w++)
            line_key[w] = '0;
        key_fill   = 0;
        line_hash  = '0;
        value_acc  = 0;
        phase      = PH_NAME;
        int_digits = 0;
        neg_value  = 0;
        bad_number = 0;
        too_long   = 0;
        line_len   = 0;
    endtask

    task automatic push_result(logic kind, int idx, logic is_new, status_t st, logic [63:0] kw,
                               int klen, bit has_stats, int e);
        agg_result_t r;
        r.kind        = kind;
        r.entry_index = idx[12:0];
        r.is_new      = is_new;
        r.status      = st;
        r.key_word    = kw;
        r.key_length  = klen[7:0];
        r.mn          = has_stats ? st_min[e][10:0] : '0;
        r.mx          = has_stats ? st_max[e][10:0] : '0;
        r.sum         = has_stats ? st_sum[e][47:0] : '0;
        r.cnt         = has_stats ? st_cnt[e] : '0;
        r.total       = keys_stored[13:0];
        expected_results.push_back(r);
    endtask

    function automatic bit key_equal(int e);
        if (stored_len[e] != key_fill)
            return 0;
        for (int w = 0; w < KWORDS; w++)
            if (stored_key[e][w] != line_key[w])
                return 0;
        return 1;
    endfunction

    task automatic close_line();
        int  v;
        int  slot;
        int  e;
        bit  found;
        bit  empty;
        found = 0;
        empty = 0;
        slot  = 0;
        if (too_long)
        begin
            push_result(KIND_LINE, 0, 0, ST_LONG, line_key[0], key_fill, 0, 0);
            return;
        end
        if (bad_number || (phase != PH_INT && phase != PH_FRAC))
        begin
            push_result(KIND_LINE, 0, 0, ST_BADNUM, line_key[0], key_fill, 0, 0);
            return;
        end
        v = (phase == PH_INT) ? value_acc * 10 : value_acc;
        if (neg_value)
            v = -v;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot = (line_hash[13:0] + i) % SLOTS;
            if (!slot_used[slot])
            begin
                empty = 1;
                break;
            end
            if (slot_entry[slot] < ENTRIES && key_equal(slot_entry[slot]))
            begin
                found = 1;
                break;
            end
        end
        if (found)
        begin
            e = slot_entry[slot];
            if (v < st_min[e])
                st_min[e] = v;
            if (v > st_max[e])
                st_max[e] = v;
            st_sum[e] += v;
            if (st_cnt[e] != 32'hFFFF_FFFF)
                st_cnt[e]++;
            push_result(KIND_LINE, e, 0, ST_OK, line_key[0], key_fill, 1, e);
            return;
        end
        if (!empty || keys_stored >= ENTRIES)
        begin
            push_result(KIND_LINE, 0, 0, ST_FULL, line_key[0], key_fill, 0, 0);
            return;
        end
        e = keys_stored;
        keys_stored++;
        slot_used[slot]  = 1;
        slot_entry[slot] = e;
        for (int w = 0; w < KWORDS; w++)
            stored_key[e][w] = line_key[w];
        stored_len[e] = key_fill;
        st_min[e] = v;
        st_max[e] = v;
        st_sum[e] = v;
        st_cnt[e] = 1;
        push_result(KIND_LINE, e, 1, ST_OK, line_key[0], key_fill, 1, e);
    endtask

    task automatic predict_item(in_item_t it);
        logic [7:0] b;
        bit         digit;
        int         idx;
        b     = it.data_byte;
        digit = (b >= CHAR_ZERO && b <= CHAR_NINE);
        idx   = it.read_index;
        if (it.cmd == CMD_READ)
        begin
            if (idx >= keys_stored)
                push_result(KIND_READ, idx, 0, ST_UNUSED, '0, 0, 0, 0);
            else
                push_result(KIND_READ, idx, 0, ST_OK, stored_key[idx][it.read_word],
                            stored_len[idx], 1, idx);
            return;
        end
        if (b == CHAR_NL)
        begin
            close_line();
            clear_line();
            return;
        end
        if (too_long)
            return;
        line_len++;
        if (line_len > LINE_MAX - 1)
        begin
            too_long = 1;
            return;
        end
        if (phase == PH_NAME)
        begin
            if (b == CHAR_SEMI)
                phase = PH_SIGN;
            else if (key_fill >= KBYTES)
                too_long = 1;
            else
            begin
                line_key[key_fill / 8][(key_fill % 8) * 8 +: 8] = b;
                key_fill++;
                line_hash = line_hash * HASH_MULT + b;
            end
        end
        else if (phase == PH_SIGN && b == CHAR_MINUS)
        begin
            neg_value = 1;
            phase = PH_NEG;
        end
        else if (phase == PH_SIGN || phase == PH_NEG || phase == PH_INT)
        begin
            if (digit && int_digits < 2)
            begin
                value_acc = value_acc * 10 + (b - CHAR_ZERO);
                int_digits++;
                phase = PH_INT;
            end
            else if (b == CHAR_DOT && phase == PH_INT)
                phase = PH_DOT;
            else
                bad_number = 1;
        end
        else if (phase == PH_DOT)
        begin
            if (digit)
            begin
                value_acc = value_acc * 10 + (b - CHAR_ZERO);
                phase = PH_FRAC;
            end
            else
                bad_number = 1;
        end
        else
            bad_number = 1;
    endtask

    // stimulus builders
    task automatic add_byte(logic [7:0] b);
        in_item_t it;
        it.cmd        = CMD_STREAM;
        it.data_byte  = b;
        it.read_index = 13'($urandom);
        it.read_word  = 4'($urandom);
        it.hold       = 0;
        pending_items.push_back(it);
    endtask

    task automatic add_read(int idx, int w);
        in_item_t it;
        it.cmd        = CMD_READ;
        it.data_byte  = 8'($urandom);
        it.read_index = idx[12:0];
        it.read_word  = w[3:0];
        it.hold       = 0;
        pending_items.push_back(it);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_line(bytes_t name, string val);
        foreach (name[i])
            add_byte(name[i]);
        add_byte(CHAR_SEMI);
        add_text(val);
        add_byte(CHAR_NL);
    endtask

    function automatic bytes_t text_bytes(string s);
        bytes_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic bytes_t random_name(int len);
        bytes_t     q;
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            do
                b = 8'($urandom);
            while (b == CHAR_NL || b == CHAR_SEMI);
            q.push_back(b);
        end
        return q;
    endfunction

    function automatic string random_value();
        string s;
        s = ($urandom_range(1) == 1) ? "-" : "";
        s = {s, $sformatf("%0d", $urandom_range(99))};
        if ($urandom_range(2) != 0)
            s = {s, $sformatf(".%0d", $urandom_range(9))};
        return s;
    endfunction

    function automatic string broken_value();
        case ($urandom_range(4))
            0: return $sformatf("%0d", 100 + $urandom_range(899));
            1: return $sformatf("%0d.", $urandom_range(9));
            2: return $sformatf("%0d;%0d", $urandom_range(9), $urandom_range(9));
            3: return $sformatf(".%0d", $urandom_range(9));
            default: return "-";
        endcase
    endfunction

    function automatic int keys_guess();
        return 60;
    endfunction

    task automatic build_stimulus();
        bytes_t pool[$];
        bytes_t nm;
        bytes_t longname;
        string  filler;
        int     r;
        // directed part
        add_line(text_bytes("a"), "0");
        add_line(text_bytes("a"), "-99.9");
        add_line(text_bytes("a"), "99.9");
        nm = text_bytes("a");
        nm.push_back(8'h00);
        add_line(nm, "12");
        add_line(nm, "-5");
        nm = {};
        add_line(nm, "1.5");
        add_line(text_bytes("b"), "");
        add_text("nosep");
        add_byte(CHAR_NL);
        add_line(text_bytes("c"), "1;2");
        add_line(text_bytes("d"), "123");
        add_line(text_bytes("e"), "1.");
        add_line(text_bytes("f"), ".5");
        add_line(text_bytes("g"), "--1");
        longname = random_name(KBYTES);
        add_line(longname, "7");
        add_line(longname, "-3.3");
        add_line(random_name(KBYTES + 1), "1");
        filler = "";
        for (int i = 0; i < 160; i++)
            filler = {filler, "9"};
        add_line(random_name(100), filler);
        add_text("hal");
        add_read(0, 0);
        add_text("f;4");
        add_read(1, 0);
        add_text(".2");
        add_byte(CHAR_NL);
        add_read(0, 15);
        add_read(5, 1);
        add_read(8191, 15);
        add_byte(8'hFF);
        add_byte(CHAR_NL);
        // random part
        for (int i = 0; i < 40; i++)
            pool.push_back(random_name($urandom_range(1, 20)));
        pool.push_back(longname);
        while (pending_items.size() < 1250)
        begin
            if (pending_items.size() > 600 && pending_items.size() < 620)
                pending_items[pending_items.size() - 1].hold = 1;
            r = $urandom_range(99);
            nm = pool[$urandom_range(pool.size() - 1)];
            if (r < 70)
            begin
                if ($urandom_range(5) == 0)
                begin
                    foreach (nm[i])
                        add_byte(nm[i]);
                    add_read($urandom_range(keys_guess()), $urandom_range(15));
                    add_byte(CHAR_SEMI);
                    add_text(random_value());
                    add_byte(CHAR_NL);
                end
                else
                    add_line(nm, random_value());
            end
            else if (r < 80)
                add_line(nm, broken_value());
            else if (r < 92)
                add_read(($urandom_range(3) == 0) ? $urandom_range(8191)
                                                  : $urandom_range(keys_guess()),
                         $urandom_range(15));
            else if (r < 96)
            begin
                repeat ($urandom_range(1, 12))
                    add_byte(8'($urandom));
                add_byte(CHAR_NL);
            end
            else
                add_line(random_name($urandom_range(1, 6)), random_value());
        end
        items_total = pending_items.size();
    endtask

    function automatic int cur_phase();
        return (items_sent * 4) / (items_total + 1);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_item(cur_item);
                items_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (stimulus_ready && pending_items.size() != 0
                    && !(pending_items[0].hold && expected_results.size() != 0)
                    && !(cur_phase() == 1 && $urandom_range(99) < 80)
                    && !(cur_phase() == 3 && $urandom_range(99) < 26))
                begin
                    cur_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'b0, cur_item.read_word, cur_item.read_index,
                                      cur_item.data_byte};
                    s_axis_tuser  <= cur_item.cmd;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        agg_result_t e;
        agg_result_t a;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                a.kind        = m_axis_tuser;
                a.entry_index = m_axis_tdata[12:0];
                a.is_new      = m_axis_tdata[13];
                a.status      = m_axis_tdata[16:14];
                a.key_word    = m_axis_tdata[80:17];
                a.key_length  = m_axis_tdata[88:81];
                a.mn          = m_axis_tdata[99:89];
                a.mx          = m_axis_tdata[110:100];
                a.sum         = m_axis_tdata[158:111];
                a.cnt         = m_axis_tdata[190:159];
                a.total       = m_axis_tdata[204:191];
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output item: %p", a);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (a.kind !== e.kind || a.entry_index !== e.entry_index
                        || a.is_new !== e.is_new || a.status !== e.status
                        || a.key_word !== e.key_word || a.key_length !== e.key_length
                        || a.mn !== e.mn || a.mx !== e.mx || a.sum !== e.sum
                        || a.cnt !== e.cnt || a.total !== e.total)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch\n  expected %p\n  actual   %p", e, a);
                    end
                end
            end
            case (cur_phase())
                2: m_axis_tready <= ($urandom_range(99) >= 80);
                3: m_axis_tready <= ($urandom_range(99) >= 26);
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        items_sent     = 0;
        items_total    = 1;
        mismatches     = 0;
        stimulus_ready = 0;
        keys_stored    = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_used[i]  = 0;
            slot_entry[i] = 0;
        end
        clear_line();
        rst_n = 1'b0;
        build_stimulus();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        stimulus_ready = 1;
        wait (pending_items.size() == 0);
        @(posedge clk);
        while (s_axis_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/kmms_pkg.sv
rtl/core/kmms_queue.sv
rtl/core/kmms_front.sv
rtl/core/kmms_back.sv
rtl/core/keyed_min_max_sum_aggregator.sv
rtl/core/kmms_checker.sv
tb/tb_keyed_min_max_sum_aggregator.sv
